@@ rtl/dtp_pkg.sv @@
package dtp_pkg;

	// Message and length-field limits
	localparam int unsigned MSG_W             = 11;
	localparam int unsigned MAX_MESSAGE_BYTES = 1024;
	localparam int unsigned MAX_LENGTH_BYTES  = 4;
	localparam int unsigned HEX_CHAR_LIMIT    = 2036;

	// Tag and length byte masks
	localparam logic [7:0] CONSTRUCTED_MASK = 8'h20;
	localparam logic [7:0] LONG_FORM_MASK   = 8'h80;
	localparam logic [7:0] LENGTH_MASK      = 8'h7F;

	// Result queue geometry (depth is a power of two)
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Token kinds
	localparam logic [2:0] TOK_CONS_HDR = 3'd0;
	localparam logic [2:0] TOK_PRIM_HDR = 3'd1;
	localparam logic [2:0] TOK_CONTENT  = 3'd2;
	localparam logic [2:0] TOK_DONE     = 3'd3;
	localparam logic [2:0] TOK_ERROR    = 3'd4;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_LEN_BYTES = 3'd1;
	localparam logic [2:0] ERR_OVERRUN   = 3'd2;
	localparam logic [2:0] ERR_TRUNC     = 3'd3;
	localparam logic [2:0] ERR_SIZE      = 3'd4;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN,
		PH_LONG,
		PH_CONTENT,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       token_kind;
		logic [7:0]       tag_value;
		logic [MSG_W-1:0] item_length;
		logic [7:0]       content_byte;
		logic [2:0]       error_code;
		logic             final_res;
	} result_t;

	// Parser state; the long-form length keeps its low bits plus a sticky
	// flag for anything that landed above them
	typedef struct packed {
		phase_t           phase;
		logic [7:0]       held_tag;
		logic             constructed;
		logic [2:0]       len_left;
		logic [MSG_W-1:0] acc_lo;
		logic             acc_big;
		logic [MSG_W-1:0] content_left;
		logic [MSG_W-1:0] byte_pos;
	} dtp_state_t;

	// Up to two results produced by one byte
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} res_pair_t;

	localparam dtp_state_t STATE_RESET = '{
		phase:        PH_TAG,
		held_tag:     '0,
		constructed:  1'b0,
		len_left:     '0,
		acc_lo:       '0,
		acc_big:      1'b0,
		content_left: '0,
		byte_pos:     '0
	};

endpackage

@@ rtl/dtp_step.sv @@
module dtp_step (
	input  dtp_pkg::dtp_state_t           state,
	input  dtp_pkg::in_item_t             item,
	input  logic [dtp_pkg::MSG_W-1:0]     msg_bytes,
	output dtp_pkg::dtp_state_t           state_next,
	output dtp_pkg::res_pair_t            res
);
	import dtp_pkg::*;

	logic [7:0]       b;
	logic             last;
	logic             skip;
	logic [MSG_W:0]   pos;
	logic             size_bad;
	logic             count_bad;
	logic             long_form;
	logic [6:0]       n_cnt;
	logic             n_bad;
	logic             n_zero;
	logic [2:0]       len_left_dec;
	logic [MSG_W-1:0] acc_lo_nx;
	logic             acc_big_nx;
	logic             header;
	logic [MSG_W-1:0] hlen_lo;
	logic             hlen_big;
	logic [MSG_W-1:0] rem;
	logic             err_len;
	logic             overrun;
	logic             any_err;
	logic [2:0]       err_code;
	logic [MSG_W-1:0] content_dec;
	phase_t           phase_mid;
	logic             has_primary;
	result_t          prim_res;
	result_t          end_res;
	result_t          err_res;

	function automatic result_t mk_res(input logic [2:0] kind, input logic [7:0] tag,
			input logic [MSG_W-1:0] len, input logic [7:0] cb, input logic [2:0] err);
		result_t r;
		r.token_kind   = kind;
		r.tag_value    = tag;
		r.item_length  = len;
		r.content_byte = cb;
		r.error_code   = err;
		r.final_res    = 1'b0;
		return r;
	endfunction

	// Decode the incoming byte against the current state
	assign b    = item.data_byte;
	assign last = item.last_byte;
	assign skip = (state.phase == PH_SKIP);
	assign pos  = {1'b0, state.byte_pos} + (MSG_W+1)'(1);

	assign size_bad = (state.byte_pos == '0) &&
		((msg_bytes == '0) ||
		 ({msg_bytes, 1'b0} >= (MSG_W+1)'(HEX_CHAR_LIMIT)) ||
		 ({{(32-MSG_W){1'b0}}, msg_bytes} > 32'(MAX_MESSAGE_BYTES)));
	assign count_bad = last ? (pos != {1'b0, msg_bytes}) : (pos >= {1'b0, msg_bytes});

	assign long_form    = (b & LONG_FORM_MASK) != '0;
	assign n_cnt        = b[6:0] & LENGTH_MASK[6:0];
	assign n_bad        = n_cnt > 7'(MAX_LENGTH_BYTES);
	assign n_zero       = (n_cnt == '0);
	assign len_left_dec = state.len_left - 3'd1;

	// Shift in one length byte; bits pushed above the low word go sticky
	assign acc_lo_nx  = {state.acc_lo[2:0], b};
	assign acc_big_nx = state.acc_big | (state.acc_lo[MSG_W-1:3] != '0);

	assign header = ((state.phase == PH_LEN) && (!long_form || n_zero)) ||
		((state.phase == PH_LONG) && (len_left_dec == '0));
	assign hlen_lo  = (state.phase == PH_LONG) ? acc_lo_nx :
		(long_form ? '0 : {{(MSG_W-7){1'b0}}, n_cnt});
	assign hlen_big = (state.phase == PH_LONG) && acc_big_nx;
	assign rem      = msg_bytes - pos[MSG_W-1:0];

	assign err_len     = (state.phase == PH_LEN) && long_form && n_bad;
	assign overrun     = header && (hlen_big || (hlen_lo > rem));
	assign any_err     = size_bad || count_bad || err_len || overrun;
	assign content_dec = state.content_left - MSG_W'(1);

	// Pick the reported error, earliest check first
	always_comb begin
		if (size_bad) begin
			err_code = ERR_SIZE;
		end else if (count_bad) begin
			err_code = ERR_TRUNC;
		end else if (err_len) begin
			err_code = ERR_LEN_BYTES;
		end else begin
			err_code = ERR_OVERRUN;
		end
	end

	// Phase after this byte on an error-free path
	always_comb begin
		unique case (state.phase)
			PH_TAG:     phase_mid = PH_LEN;
			PH_LEN:     phase_mid = (long_form && !n_zero) ? PH_LONG : PH_TAG;
			PH_LONG:    phase_mid = PH_LONG;
			PH_CONTENT: phase_mid = (content_dec == '0) ? PH_TAG : PH_CONTENT;
			default:    phase_mid = PH_TAG;
		endcase
		if (header) begin
			phase_mid = (state.constructed || (hlen_lo == '0)) ? PH_TAG : PH_CONTENT;
		end
	end

	// Next state
	always_comb begin
		state_next = state;
		if (skip) begin
			if (last) begin
				state_next.phase    = PH_TAG;
				state_next.byte_pos = '0;
			end
		end else if (size_bad || count_bad) begin
			state_next.phase = last ? PH_TAG : PH_SKIP;
			if (last) begin
				state_next.byte_pos = '0;
			end
		end else begin
			state_next.byte_pos = pos[MSG_W-1:0];
			unique case (state.phase)
				PH_TAG: begin
					state_next.held_tag    = b;
					state_next.constructed = (b & CONSTRUCTED_MASK) != '0;
				end
				PH_LEN: begin
					if (long_form && !n_zero) begin
						state_next.len_left = n_cnt[2:0];
						state_next.acc_lo   = '0;
						state_next.acc_big  = 1'b0;
					end
				end
				PH_LONG: begin
					state_next.len_left = len_left_dec;
					state_next.acc_lo   = acc_lo_nx;
					state_next.acc_big  = acc_big_nx;
				end
				PH_CONTENT: begin
					state_next.content_left = content_dec;
				end
				default: begin
				end
			endcase
			if (header && !state.constructed) begin
				state_next.content_left = hlen_lo;
			end
			if (err_len || overrun) begin
				state_next.phase = last ? PH_TAG : PH_SKIP;
			end else if (last) begin
				state_next.phase = PH_TAG;
			end else begin
				state_next.phase = phase_mid;
			end
			if (last) begin
				state_next.byte_pos = '0;
			end
		end
	end

	// Candidate results
	always_comb begin
		has_primary = header || (state.phase == PH_CONTENT);
		if (header) begin
			prim_res = mk_res(state.constructed ? TOK_CONS_HDR : TOK_PRIM_HDR,
				state.held_tag, hlen_lo, 8'd0, ERR_NONE);
		end else begin
			prim_res = mk_res(TOK_CONTENT, 8'd0, '0, b, ERR_NONE);
		end
		if (phase_mid == PH_TAG) begin
			end_res = mk_res(TOK_DONE, 8'd0, '0, 8'd0, ERR_NONE);
		end else begin
			end_res = mk_res(TOK_ERROR, 8'd0, '0, 8'd0, ERR_TRUNC);
		end
		end_res.final_res = 1'b1;
		err_res           = mk_res(TOK_ERROR, 8'd0, '0, 8'd0, err_code);
		err_res.final_res = 1'b1;
	end

	// Order the results of this byte, flag the last one
	always_comb begin
		res.num = 2'd0;
		res.r0  = '0;
		res.r1  = '0;
		if (!skip) begin
			if (any_err) begin
				res.num = 2'd1;
				res.r0  = err_res;
			end else if (has_primary && last) begin
				res.num = 2'd2;
				res.r0  = prim_res;
				res.r1  = end_res;
			end else if (has_primary) begin
				res.num          = 2'd1;
				res.r0           = prim_res;
				res.r0.final_res = 1'b1;
			end else if (last) begin
				res.num = 2'd1;
				res.r0  = end_res;
			end
		end
	end

endmodule

@@ rtl/dtp_result_fifo.sv @@
module dtp_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  dtp_pkg::res_pair_t  push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output dtp_pkg::result_t    out_data
);
	import dtp_pkg::*;

	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W-1:0] wr_ptr_nx1;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [1:0]            push_cnt;
	logic                  pop;
	result_t               mem_q [FIFO_DEPTH];

	assign push_cnt   = push_en ? push.num : 2'd0;
	assign pop        = out_valid && !out_stall;
	assign wr_ptr_nx1 = wr_ptr_q + FIFO_PTR_W'(1);

	// Leave space for a two-result byte
	assign room      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
			count_q  <= count_q + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
		end
	end

	// Store one or two results per beat
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_nx1] <= push.r1;
		end
	end

endmodule

@@ rtl/der_tlv_stream_parser_core.sv @@
// DER TLV stream parser.
// Input channel (in_valid / in_stall / in_data) takes one byte of a DER message
// per beat, with last_byte marking the final byte. Output channel (out_valid /
// out_stall / out_data) delivers headers, content bytes, a done token after a
// well-formed message, or an error token; final_res marks the last result of
// each byte. cfg_wr_en / cfg_wr_data load the message size before streaming.
// An accepted byte is held in the input register, parsed once the queue has room,
// and its results are written to the result queue and offered from there.
// Throughput: one byte per cycle while the output is not stalled and bytes give
// at most one result; the two results of one byte leave one per output beat.
// The input register and the parser step form one stage; a four-entry result
// queue sits behind it and sets how much output stall is absorbed.
// Reset clears the size register to zero, returns the parser to the tag phase,
// and empties the input register and the result queue.
// When the receiver stalls, the queue fills; once it lacks room for two results
// the held byte waits in the input register and in_stall is raised.
module der_tlv_stream_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dtp_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output dtp_pkg::result_t              out_data,
	input  logic                          cfg_wr_en,
	input  logic [dtp_pkg::MSG_W-1:0]     cfg_wr_data
);
	import dtp_pkg::*;

	logic             valid_s1;
	in_item_t         item_s1;
	dtp_state_t       state_q;
	dtp_state_t       state_next;
	logic [MSG_W-1:0] msg_bytes_q;
	res_pair_t        step_res;
	logic             room;
	logic             proc;
	logic             accept;

	// Parse the held byte when the queue can take its results
	assign proc     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// Message size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_bytes_q <= '0;
		end else if (cfg_wr_en) begin
			msg_bytes_q <= cfg_wr_data;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (proc) begin
			state_q <= state_next;
		end
	end

	dtp_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.msg_bytes  (msg_bytes_q),
		.state_next (state_next),
		.res        (step_res)
	);

	dtp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (proc),
		.push      (step_res),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
